// File: design/pwiu_pkg.sv
// Shared constants and types for the periodic wrap and image unwrap block.
`timescale 1ns / 1ps

package pwiu_pkg;

    localparam int DEF_COUNTER_BITS = 10;
    localparam int DEF_COORD_BITS   = 32;
    localparam int UNWRAP_BITS      = 48;
    localparam int NUM_AXES         = 3;
    localparam int NUM_STAGES       = 4;
    localparam int CFG_IDX_W        = 3;

    // Q16.16 value of 1.0, the period after reset.
    localparam longint PERIOD_RESET   = 65536;
    localparam longint LOW_EDGE_RESET = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_EDGE_X = 3'd0,
        REG_LOW_EDGE_Y = 3'd1,
        REG_LOW_EDGE_Z = 3'd2,
        REG_PERIOD_X   = 3'd3,
        REG_PERIOD_Y   = 3'd4,
        REG_PERIOD_Z   = 3'd5
    } pwiu_reg_t;

    // Load enables of the pipeline registers, stage 0 first.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pwiu_pipe_ctrl_t;

endpackage

// File: design/pwiu_in_if.sv
// Input channel interface: one particle per transaction.
`timescale 1ns / 1ps

interface pwiu_in_if #(
    parameter int COORD_BITS   = pwiu_pkg::DEF_COORD_BITS,
    parameter int COUNTER_BITS = pwiu_pkg::DEF_COUNTER_BITS
);
    logic                                                valid;
    logic                                                ready;
    logic signed [COORD_BITS-1:0]                        pos_x;
    logic signed [COORD_BITS-1:0]                        pos_y;
    logic signed [COORD_BITS-1:0]                        pos_z;
    logic [pwiu_pkg::NUM_AXES*COUNTER_BITS-1:0]          image_word;
    logic                                                last_particle;

    modport source (
        output valid, pos_x, pos_y, pos_z, image_word, last_particle,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, image_word, last_particle,
        output ready
    );
endinterface

// File: design/pwiu_out_if.sv
// Output channel interface: one wrapped and unwrapped particle per transaction.
`timescale 1ns / 1ps

interface pwiu_out_if #(
    parameter int COORD_BITS   = pwiu_pkg::DEF_COORD_BITS,
    parameter int COUNTER_BITS = pwiu_pkg::DEF_COUNTER_BITS
);
    logic                                                valid;
    logic                                                ready;
    logic signed [COORD_BITS-1:0]                        wrapped_x;
    logic signed [COORD_BITS-1:0]                        wrapped_y;
    logic signed [COORD_BITS-1:0]                        wrapped_z;
    logic [pwiu_pkg::NUM_AXES*COUNTER_BITS-1:0]          new_image_word;
    logic signed [pwiu_pkg::UNWRAP_BITS-1:0]             unwrapped_x;
    logic signed [pwiu_pkg::UNWRAP_BITS-1:0]             unwrapped_y;
    logic signed [pwiu_pkg::UNWRAP_BITS-1:0]             unwrapped_z;
    logic                                                last_out;

    modport source (
        output valid, wrapped_x, wrapped_y, wrapped_z, new_image_word,
               unwrapped_x, unwrapped_y, unwrapped_z, last_out,
        input  ready
    );
    modport sink (
        input  valid, wrapped_x, wrapped_y, wrapped_z, new_image_word,
               unwrapped_x, unwrapped_y, unwrapped_z, last_out,
        output ready
    );
endinterface

// File: design/pwiu_cfg.sv
// Box configuration registers with a precomputed high edge per axis.
`timescale 1ns / 1ps

module pwiu_cfg #(
    parameter int COORD_BITS = pwiu_pkg::DEF_COORD_BITS
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   cfg_we,
    input  logic [pwiu_pkg::CFG_IDX_W-1:0]                         cfg_index,
    input  logic [COORD_BITS-1:0]                                  cfg_data,
    output logic [pwiu_pkg::NUM_AXES-1:0][COORD_BITS-1:0]          low_edge,
    output logic [pwiu_pkg::NUM_AXES-1:0][COORD_BITS-2:0]          period,
    output logic [pwiu_pkg::NUM_AXES-1:0][COORD_BITS:0]            high_edge
);

    logic [pwiu_pkg::NUM_AXES-1:0][COORD_BITS-1:0] low_reg;
    logic [pwiu_pkg::NUM_AXES-1:0][COORD_BITS-2:0] period_reg;
    logic [pwiu_pkg::NUM_AXES-1:0][COORD_BITS:0]   high_reg;
    logic [pwiu_pkg::NUM_AXES-1:0][COORD_BITS:0]   high_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < pwiu_pkg::NUM_AXES; a++)
            begin
                low_reg[a]    <= COORD_BITS'(pwiu_pkg::LOW_EDGE_RESET);
                period_reg[a] <= (COORD_BITS-1)'(pwiu_pkg::PERIOD_RESET);
            end
        end
        else if (cfg_we)
        begin
            case (pwiu_pkg::pwiu_reg_t'(cfg_index))
                pwiu_pkg::REG_LOW_EDGE_X: low_reg[0]    <= cfg_data;
                pwiu_pkg::REG_LOW_EDGE_Y: low_reg[1]    <= cfg_data;
                pwiu_pkg::REG_LOW_EDGE_Z: low_reg[2]    <= cfg_data;
                pwiu_pkg::REG_PERIOD_X:   period_reg[0] <= cfg_data[COORD_BITS-2:0];
                pwiu_pkg::REG_PERIOD_Y:   period_reg[1] <= cfg_data[COORD_BITS-2:0];
                pwiu_pkg::REG_PERIOD_Z:   period_reg[2] <= cfg_data[COORD_BITS-2:0];
                default: ;
            endcase
        end
    end

    // The high edge is one bit wider than a coordinate so it never wraps.
    always_comb
    begin
        for (int a = 0; a < pwiu_pkg::NUM_AXES; a++)
        begin
            high_next[a] = {low_reg[a][COORD_BITS-1], low_reg[a]}
                         + {2'b00, period_reg[a]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= '0;
        end
        else
        begin
            high_reg <= high_next;
        end
    end

    assign low_edge  = low_reg;
    assign period    = period_reg;
    assign high_edge = high_reg;

endmodule

// File: design/pwiu_ctrl.sv
// Pipeline valid bits, stall chain and the batch marker that rides along.
`timescale 1ns / 1ps

module pwiu_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_last,
    output pwiu_pkg::pwiu_pipe_ctrl_t  pipe
);

    localparam int NS = pwiu_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] last_reg;
    logic [NS-1:0] load;

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb
    begin
        load[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            last_reg[0] <= in_last;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (load[k])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NS-1];
    assign out_last  = last_reg[NS-1];
    assign pipe.load = load;

endmodule

// File: design/pwiu_axis.sv
// Four-stage datapath of one axis: low check, high check, image multiply, unwrap sum.
`timescale 1ns / 1ps

module pwiu_axis #(
    parameter int COORD_BITS   = pwiu_pkg::DEF_COORD_BITS,
    parameter int COUNTER_BITS = pwiu_pkg::DEF_COUNTER_BITS
) (
    input  logic                                   clk,
    input  pwiu_pkg::pwiu_pipe_ctrl_t              pipe,
    input  logic [COORD_BITS-1:0]                  low_edge,
    input  logic [COORD_BITS-2:0]                  period,
    input  logic [COORD_BITS:0]                    high_edge,
    input  logic signed [COORD_BITS-1:0]           pos,
    input  logic [COUNTER_BITS-1:0]                cnt_in,
    output logic signed [COORD_BITS-1:0]           wrapped,
    output logic signed [pwiu_pkg::UNWRAP_BITS-1:0] unwrapped,
    output logic [COUNTER_BITS-1:0]                cnt_out
);

    localparam int UW     = pwiu_pkg::UNWRAP_BITS;
    localparam int PROD_W = COUNTER_BITS + COORD_BITS;
    localparam int SUM_W  = ((PROD_W > UW) ? PROD_W : UW) + 1;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [UW-1:0]         UW_MAX    = {1'b0, {(UW-1){1'b1}}};
    localparam logic signed [UW-1:0]         UW_MIN    = {1'b1, {(UW-1){1'b0}}};

    logic signed [COORD_BITS-1:0] lo_s;
    logic signed [COORD_BITS-1:0] p_s;
    logic signed [COORD_BITS:0]   hi_s;

    assign lo_s = $signed(low_edge);
    assign p_s  = $signed({1'b0, period});
    assign hi_s = $signed(high_edge);

    // Stage 1: below the low edge, add one period with saturation.
    logic signed [COORD_BITS-1:0] s1_x_reg,  s1_x_next;
    logic [COUNTER_BITS-1:0]      s1_c_reg,  s1_c_next;
    logic signed [COORD_BITS:0]   s1_sum;

    always_comb
    begin
        s1_sum    = (COORD_BITS+1)'(pos) + (COORD_BITS+1)'(p_s);
        s1_x_next = pos;
        s1_c_next = cnt_in;
        if (pos < lo_s)
        begin
            s1_c_next = cnt_in - COUNTER_BITS'(1);
            if (s1_sum[COORD_BITS] != s1_sum[COORD_BITS-1])
            begin
                s1_x_next = COORD_MAX;
            end
            else
            begin
                s1_x_next = s1_sum[COORD_BITS-1:0];
            end
        end
    end

    // Stage 2: at or above the high edge, take one period off. Since the
    // coordinate is at least low edge plus period, the result never drops
    // below the low edge, so no clamp is needed.
    logic signed [COORD_BITS-1:0]   s2_x_reg,   s2_x_next;
    logic [COUNTER_BITS-1:0]        s2_c_reg,   s2_c_next;
    logic signed [COUNTER_BITS-1:0] s2_off_reg, s2_off_next;

    always_comb
    begin
        s2_x_next = s1_x_reg;
        s2_c_next = s1_c_reg;
        if ((COORD_BITS+1)'(s1_x_reg) >= hi_s)
        begin
            s2_x_next = s1_x_reg - p_s;
            s2_c_next = s1_c_reg + COUNTER_BITS'(1);
        end
        // Removing the bias is an inversion of the counter's top bit.
        s2_off_next = $signed({~s2_c_next[COUNTER_BITS-1], s2_c_next[COUNTER_BITS-2:0]});
    end

    // Stage 3: image offset times period.
    logic signed [COORD_BITS-1:0] s3_x_reg;
    logic [COUNTER_BITS-1:0]      s3_c_reg;
    logic signed [PROD_W-1:0]     s3_prod_reg, s3_prod_next;

    assign s3_prod_next = PROD_W'(s2_off_reg) * PROD_W'(p_s);

    // Stage 4: unwrapped sum, saturated to the output range.
    logic signed [COORD_BITS-1:0] s4_x_reg;
    logic [COUNTER_BITS-1:0]      s4_c_reg;
    logic signed [UW-1:0]         s4_u_reg, s4_u_next;
    logic signed [SUM_W-1:0]      s4_sum;

    always_comb
    begin
        s4_sum = SUM_W'(s3_x_reg) + SUM_W'(s3_prod_reg);
        if (s4_sum[SUM_W-1:UW-1] == {(SUM_W-UW+1){s4_sum[SUM_W-1]}})
        begin
            s4_u_next = s4_sum[UW-1:0];
        end
        else if (s4_sum[SUM_W-1])
        begin
            s4_u_next = UW_MIN;
        end
        else
        begin
            s4_u_next = UW_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[0])
        begin
            s1_x_reg <= s1_x_next;
            s1_c_reg <= s1_c_next;
        end
        if (pipe.load[1])
        begin
            s2_x_reg   <= s2_x_next;
            s2_c_reg   <= s2_c_next;
            s2_off_reg <= s2_off_next;
        end
        if (pipe.load[2])
        begin
            s3_x_reg    <= s2_x_reg;
            s3_c_reg    <= s2_c_reg;
            s3_prod_reg <= s3_prod_next;
        end
        if (pipe.load[3])
        begin
            s4_x_reg <= s3_x_reg;
            s4_c_reg <= s3_c_reg;
            s4_u_reg <= s4_u_next;
        end
    end

    assign wrapped   = s4_x_reg;
    assign unwrapped = s4_u_reg;
    assign cnt_out   = s4_c_reg;

endmodule

// File: design/periodic_wrap_image_unwrap.sv
// Top level of the periodic box wrap with packed image counters.
//
// Usage:
//   in_ch carries one particle per transaction: three Q16.16 coordinates, a
//   packed word of three image counters biased by half their range, and a
//   batch marker. out_ch returns one transaction per particle, in order: the
//   wrapped coordinates, the updated image word, the Q32.16 unwrapped
//   coordinates and the batch marker.
//   The box (low edge and period per axis) is set through the plain write
//   port; write it only while no particle is in flight.
// Timing:
//   Four register stages (low check, high check, offset multiply, unwrap
//   sum). A result is registered in each stage in turn and is presented on
//   out_ch from the last one. One particle per cycle is sustained while
//   out_ch is ready; the stage depth is set by the offset-times-period
//   multiplier and the 48-bit saturating add.
// Reset:
//   Clears the pipeline and loads low edge 0 and period 1.0 on each axis.
// Stalls:
//   When out_ch is not ready, the pipeline fills its empty stages first and
//   then holds; in_ch.ready falls only once all four stages are occupied.
`timescale 1ns / 1ps

module periodic_wrap_image_unwrap #(
    parameter int COUNTER_BITS = pwiu_pkg::DEF_COUNTER_BITS,
    parameter int COORD_BITS   = pwiu_pkg::DEF_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pwiu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data,
    pwiu_in_if.sink                           in_ch,
    pwiu_out_if.source                        out_ch
);

    localparam int NA = pwiu_pkg::NUM_AXES;

    logic [NA-1:0][COORD_BITS-1:0]   low_edge;
    logic [NA-1:0][COORD_BITS-2:0]   period;
    logic [NA-1:0][COORD_BITS:0]     high_edge;
    pwiu_pkg::pwiu_pipe_ctrl_t       pipe;

    logic [NA-1:0][COORD_BITS-1:0]            pos;
    logic [NA-1:0][COORD_BITS-1:0]            wrapped;
    logic [NA-1:0][pwiu_pkg::UNWRAP_BITS-1:0] unwrapped;

    pwiu_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .low_edge  (low_edge),
        .period    (period),
        .high_edge (high_edge)
    );

    pwiu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_last   (in_ch.last_particle),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_last  (out_ch.last_out),
        .pipe      (pipe)
    );

    assign pos[0] = in_ch.pos_x;
    assign pos[1] = in_ch.pos_y;
    assign pos[2] = in_ch.pos_z;

    for (genvar a = 0; a < NA; a++)
    begin : g_axis
        pwiu_axis #(
            .COORD_BITS   (COORD_BITS),
            .COUNTER_BITS (COUNTER_BITS)
        ) u_axis (
            .clk       (clk),
            .pipe      (pipe),
            .low_edge  (low_edge[a]),
            .period    (period[a]),
            .high_edge (high_edge[a]),
            .pos       ($signed(pos[a])),
            .cnt_in    (in_ch.image_word[a*COUNTER_BITS +: COUNTER_BITS]),
            .wrapped   (wrapped[a]),
            .unwrapped (unwrapped[a]),
            .cnt_out   (out_ch.new_image_word[a*COUNTER_BITS +: COUNTER_BITS])
        );
    end

    assign out_ch.wrapped_x   = wrapped[0];
    assign out_ch.wrapped_y   = wrapped[1];
    assign out_ch.wrapped_z   = wrapped[2];
    assign out_ch.unwrapped_x = unwrapped[0];
    assign out_ch.unwrapped_y = unwrapped[1];
    assign out_ch.unwrapped_z = unwrapped[2];

`ifndef SYNTH
    // Input back-pressure only ever comes from a stalled, full output.
    a_ready_from_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("input stalled without an output stall");

    // With the receiver held ready, an accepted transaction moves through every
    // stage to the last one and is presented on out_ch.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready
        |=> out_ch.valid)
        else $error("accepted particle did not reach the output in time");

    // A full pipeline that is drained by one output transaction frees the input.
    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready) |-> in_ch.ready)
        else $error("output transaction did not free the input");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the periodic box wrap and image unwrap block.
`timescale 1ns / 1ps

module tb_top;

    localparam int     CNT_BITS = pwiu_pkg::DEF_COUNTER_BITS;
    localparam int     IMG_W    = pwiu_pkg::NUM_AXES * CNT_BITS;
    localparam int     CNT_MASK = (1 << CNT_BITS) - 1;
    localparam int     CNT_BIAS = 1 << (CNT_BITS - 1);
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam longint UNW_MAX   = (longint'(1) << (pwiu_pkg::UNWRAP_BITS - 1)) - 1;
    localparam longint UNW_MIN   = -UNW_MAX - 1;
    localparam longint PER_MAX   = 64'sh7fffffff;
    localparam int     SETTLE_CYCLES = 2 * pwiu_pkg::NUM_STAGES + 4;
    localparam int     DRAIN_LIMIT   = 100000;
    localparam int     RANDOM_PHASES = 12;
    localparam int     ITEMS_PER_PHASE = 100;
    localparam logic [IMG_W-1:0] IMG_CENTER = {pwiu_pkg::NUM_AXES{10'd512}};

    typedef struct packed {
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        logic [IMG_W-1:0] img;
        logic             last;
    } particle_t;

    typedef struct packed {
        logic [31:0]      wx;
        logic [31:0]      wy;
        logic [31:0]      wz;
        logic [IMG_W-1:0] img;
        logic [47:0]      ux;
        logic [47:0]      uy;
        logic [47:0]      uz;
        logic             last;
    } wrap_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [pwiu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    pwiu_in_if  in_ch();
    pwiu_out_if out_ch();

    periodic_wrap_image_unwrap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Local copy of the box registers used by the predictor.
    longint       box_lo  [pwiu_pkg::NUM_AXES];
    longint       box_per [pwiu_pkg::NUM_AXES];
    wrap_result_t pending_wraps[$];
    int           mismatch_count = 0;
    bit           idle_enable = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic wrap_result_t wrap_particle(particle_t p);
        logic [31:0]      coord [pwiu_pkg::NUM_AXES];
        logic [31:0]      wrapped [pwiu_pkg::NUM_AXES];
        logic [47:0]      unwrapped [pwiu_pkg::NUM_AXES];
        logic [IMG_W-1:0] new_img;
        wrap_result_t     res;
        longint           pos;
        longint           lo;
        longint           per;
        longint           unw;
        int               cnt;
        coord[0] = p.x;
        coord[1] = p.y;
        coord[2] = p.z;
        new_img = '0;
        for (int a = 0; a < pwiu_pkg::NUM_AXES; a++)
        begin
            pos = longint'($signed(coord[a]));
            lo  = box_lo[a];
            per = box_per[a];
            cnt = int'((p.img >> (CNT_BITS * a)) & CNT_MASK);
            if (pos < lo)
            begin
                pos = pos + per;
                if (pos > COORD_MAX)
                    pos = COORD_MAX;
                cnt = (cnt - 1) & CNT_MASK;
            end
            // The high edge is exact, so it can lie past the 32-bit range.
            if (pos >= lo + per)
            begin
                pos = pos - per;
                if (pos < lo)
                    pos = lo;
                cnt = (cnt + 1) & CNT_MASK;
            end
            unw = pos + longint'(cnt - CNT_BIAS) * per;
            if (unw > UNW_MAX)
                unw = UNW_MAX;
            else if (unw < UNW_MIN)
                unw = UNW_MIN;
            wrapped[a] = pos[31:0];
            unwrapped[a] = unw[47:0];
            new_img[CNT_BITS * a +: CNT_BITS] = cnt[CNT_BITS-1:0];
        end
        res.wx   = wrapped[0];
        res.wy   = wrapped[1];
        res.wz   = wrapped[2];
        res.img  = new_img;
        res.ux   = unwrapped[0];
        res.uy   = unwrapped[1];
        res.uz   = unwrapped[2];
        res.last = p.last;
        return res;
    endfunction

    function automatic logic [31:0] pick_coord(int axis);
        longint lo;
        longint per;
        longint span;
        longint v;
        lo   = box_lo[axis];
        per  = box_per[axis];
        span = (per > 0) ? per : 1;
        case ($urandom_range(0, 9))
            0, 1, 2: v = lo + longint'($urandom) % span;
            3, 4:    v = lo - 1 - longint'($urandom) % span;
            5, 6:    v = lo + per + longint'($urandom) % span;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = lo;
                    1:       v = lo - 1;
                    2:       v = lo + per;
                    default: v = lo + per - 1;
                endcase
            end
            default: v = longint'($signed($urandom));
        endcase
        if (v > COORD_MAX)
            v = COORD_MAX;
        else if (v < COORD_MIN)
            v = COORD_MIN;
        return v[31:0];
    endfunction

    function automatic logic [IMG_W-1:0] pick_image();
        logic [IMG_W-1:0] img;
        img = IMG_W'($urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            for (int a = 0; a < pwiu_pkg::NUM_AXES; a++)
            begin
                case ($urandom_range(0, 3))
                    0:       img[CNT_BITS * a +: CNT_BITS] = '0;
                    1:       img[CNT_BITS * a +: CNT_BITS] = CNT_BITS'(CNT_MASK);
                    2:       img[CNT_BITS * a +: CNT_BITS] = CNT_BITS'(CNT_BIAS);
                    default: img[CNT_BITS * a +: CNT_BITS] = CNT_BITS'(CNT_BIAS - 1);
                endcase
            end
        end
        return img;
    endfunction

    function automatic longint pick_low_edge();
        case ($urandom_range(0, 3))
            0:       return longint'($signed($urandom));
            1:       return (longint'($urandom_range(0, 16)) - 8) * 65536;
            2:       return 0;
            default: return longint'($signed($urandom)) >>> 8;
        endcase
    endfunction

    function automatic longint pick_period();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return PER_MAX;
            2:       return longint'($urandom_range(1, 255));
            3, 4:    return longint'($urandom_range(1, 64)) * 65536;
            default: return longint'($urandom_range(1, 32'h7fffffff));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: every output transaction is matched to the oldest prediction.
    always @(posedge clk)
    begin
        wrap_result_t want;
        wrap_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.wx   = out_ch.wrapped_x;
            got.wy   = out_ch.wrapped_y;
            got.wz   = out_ch.wrapped_z;
            got.img  = out_ch.new_image_word;
            got.ux   = out_ch.unwrapped_x;
            got.uy   = out_ch.unwrapped_y;
            got.uz   = out_ch.unwrapped_z;
            got.last = out_ch.last_out;
            if (pending_wraps.size() == 0)
            begin
                $display("%0t ns: result with no particle outstanding, expected none, actual %h",
                         $time, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_wraps.pop_front();
                check_field("wrapped_x", 48'(want.wx), 48'(got.wx));
                check_field("wrapped_y", 48'(want.wy), 48'(got.wy));
                check_field("wrapped_z", 48'(want.wz), 48'(got.wz));
                check_field("new_image_word", 48'(want.img), 48'(got.img));
                check_field("unwrapped_x", want.ux, got.ux);
                check_field("unwrapped_y", want.uy, got.uy);
                check_field("unwrapped_z", want.uz, got.uz);
                check_field("last_out", 48'(want.last), 48'(got.last));
            end
        end
    end

    // Output back-pressure in random bursts.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_enable && stall_left == 0 && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_particle(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz, input logic [IMG_W-1:0] img,
                                 input logic last);
        particle_t item;
        item = '{x: px, y: py, z: pz, img: img, last: last};
        @(negedge clk);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_ch.pos_x         <= px;
        in_ch.pos_y         <= py;
        in_ch.pos_z         <= pz;
        in_ch.image_word    <= img;
        in_ch.last_particle <= last;
        in_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_wraps.push_back(wrap_particle(item));
    endtask

    task automatic send_random_particle();
        send_particle(pick_coord(0), pick_coord(1), pick_coord(2), pick_image(),
                      ($urandom_range(0, 7) == 0));
    endtask

    // Waits until every predicted transaction has come back and the pipeline is empty.
    task automatic drain_pipeline();
        int waited;
        waited = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_wraps.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_wraps.size() != 0)
        begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, pending_wraps.size());
            mismatch_count++;
            pending_wraps.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input pwiu_pkg::pwiu_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pwiu_pkg::REG_LOW_EDGE_X: box_lo[0]  = longint'($signed(value));
            pwiu_pkg::REG_LOW_EDGE_Y: box_lo[1]  = longint'($signed(value));
            pwiu_pkg::REG_LOW_EDGE_Z: box_lo[2]  = longint'($signed(value));
            pwiu_pkg::REG_PERIOD_X:   box_per[0] = longint'(value[30:0]);
            pwiu_pkg::REG_PERIOD_Y:   box_per[1] = longint'(value[30:0]);
            pwiu_pkg::REG_PERIOD_Z:   box_per[2] = longint'(value[30:0]);
            default:                  ;
        endcase
    endtask

    task automatic program_box(input longint lo_x, input longint lo_y, input longint lo_z,
                               input longint per_x, input longint per_y,
                               input longint per_z);
        drain_pipeline();
        write_reg(pwiu_pkg::REG_LOW_EDGE_X, lo_x[31:0]);
        write_reg(pwiu_pkg::REG_LOW_EDGE_Y, lo_y[31:0]);
        write_reg(pwiu_pkg::REG_LOW_EDGE_Z, lo_z[31:0]);
        // Bit 31 is outside the period register and must be dropped.
        write_reg(pwiu_pkg::REG_PERIOD_X, {$urandom_range(0, 1) == 1, per_x[30:0]});
        write_reg(pwiu_pkg::REG_PERIOD_Y, {$urandom_range(0, 1) == 1, per_y[30:0]});
        write_reg(pwiu_pkg::REG_PERIOD_Z, {$urandom_range(0, 1) == 1, per_z[30:0]});
    endtask

    // Unit box after reset: far coordinates, both edges and counter wrap in both directions.
    task automatic test_reset_box();
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, IMG_CENTER, 1'b0);
        send_particle(32'h8000_0000, 32'h7fff_ffff, 32'h0000_ffff, '0, 1'b1);
        send_particle(32'h0001_0000, 32'hffff_ffff, 32'h7fff_0000, '1, 1'b0);
        send_particle(32'hffff_ffff, 32'h8000_0000, 32'h0001_0000, IMG_CENTER, 1'b1);
        send_particle(32'h0000_8000, 32'h0001_0001, 32'h8000_0001, 30'h1555_5555, 1'b0);
        send_particle(32'h7fff_ffff, 32'h0000_ffff, 32'hffff_0000, 30'h2aaa_aaaa, 1'b1);
        send_particle(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001,
                      {10'd1023, 10'd0, 10'd1023}, 1'b0);
        send_particle(32'hffff_fff0, 32'h0001_0000, 32'hffff_ffff,
                      {10'd0, 10'd1023, 10'd0}, 1'b1);
    endtask

    // Largest period and extreme low edges: saturation on the add and the subtract at the high edge.
    task automatic test_saturation();
        program_box(64'sh7fff_0000, COORD_MIN, 0, PER_MAX, PER_MAX, 1);
        send_particle(32'h7ffe_ffff, 32'h7fff_ffff, 32'h0000_0000, IMG_CENTER, 1'b0);
        send_particle(32'h8000_0000, 32'hffff_ffff, 32'h0000_0001, '0, 1'b1);
        send_particle(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, '1, 1'b0);
        send_particle(32'h0000_0000, 32'h7fff_fffe, 32'h7fff_ffff, IMG_CENTER, 1'b1);
        send_particle(32'h7fff_0000, 32'h8000_0001, 32'h8000_0000, 30'h1555_5555, 1'b0);
    endtask

    // Zero period: the coordinate passes through and the counter steps down below the low edge, up at or above it.
    task automatic test_zero_period();
        program_box(0, COORD_MIN, COORD_MAX, 0, 0, 0);
        send_particle(32'hffff_ffff, 32'h8000_0000, 32'h7fff_fffe, IMG_CENTER, 1'b0);
        send_particle(32'h0000_0000, 32'h8000_0001, 32'h7fff_ffff, '0, 1'b1);
        send_particle(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, '1, 1'b0);
        send_particle(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 30'h2aaa_aaaa, 1'b1);
    endtask

    task automatic test_random_boxes();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       program_box(pick_low_edge(), pick_low_edge(), pick_low_edge(),
                                     1, 1, 1);
                1:       program_box(COORD_MIN, COORD_MAX, 0, PER_MAX, PER_MAX, PER_MAX);
                default: program_box(pick_low_edge(), pick_low_edge(), pick_low_edge(),
                                     pick_period(), pick_period(), pick_period());
            endcase
            // The closing phases run at full rate on both sides.
            idle_enable = (phase < RANDOM_PHASES - 2);
            repeat (ITEMS_PER_PHASE)
                send_random_particle();
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = pwiu_pkg::REG_LOW_EDGE_X;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.pos_x         = '0;
        in_ch.pos_y         = '0;
        in_ch.pos_z         = '0;
        in_ch.image_word    = '0;
        in_ch.last_particle = 1'b0;
        for (int a = 0; a < pwiu_pkg::NUM_AXES; a++)
        begin
            box_lo[a]  = pwiu_pkg::LOW_EDGE_RESET;
            box_per[a] = pwiu_pkg::PERIOD_RESET;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        test_reset_box();
        test_saturation();
        test_zero_period();
        test_random_boxes();

        drain_pipeline();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
design/pwiu_pkg.sv
design/pwiu_in_if.sv
design/pwiu_out_if.sv
design/pwiu_cfg.sv
design/pwiu_ctrl.sv
design/pwiu_axis.sv
design/periodic_wrap_image_unwrap.sv
tb/tb_top.sv
